/* hdl/wheel_velocity_pid_top_macros.svh */
// ----------------------------------------------------------------------------
// Wheel velocity PID - assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef WHEEL_VELOCITY_PID_TOP_MACROS_SVH
`define WHEEL_VELOCITY_PID_TOP_MACROS_SVH

// same-cycle implication
`define WVP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wvpid_pkg.sv */
// ----------------------------------------------------------------------------
// Wheel velocity PID - package
// Word types, register indexes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package wvpid_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 2'd3;

  localparam logic [15:0] PROP_GAIN_RST      = 16'd3072;
  localparam logic [15:0] INTEG_GAIN_RST     = 16'd328;
  localparam logic [15:0] DERIV_GAIN_RST     = 16'd1024;
  localparam logic [15:0] DIST_PER_COUNT_RST = 16'd1942;

  // Q0.16 inch/count times 1e6 us/s, Q8.8 out: 2^8 * 1e6 / 2^16 = 15625 / 4
  localparam int SPEED_SCALE = 15625;
  localparam int DEN_SHIFT   = 2;
  localparam int FRAC_BITS   = 12;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  localparam logic [15:0] S16_MAX = 16'h7FFF;
  localparam logic [15:0] S16_MIN = 16'h8000;

  typedef struct packed {
    logic               cmd;
    logic        [23:0] encoder_count;
    logic        [31:0] timestamp_us;
    logic signed [15:0] target_speed;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] drive_power;
    logic signed [15:0] measured_speed;
    logic signed [15:0] speed_error;
    logic               saturated;
    logic               zero_interval;
  } out_word_t;

endpackage

/* hdl/wheel_velocity_pid_top.sv */
// ----------------------------------------------------------------------------
// Wheel velocity PID - top level
// Incremental PID speed loop for one wheel, bit-serial multiply and divide.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+------------
//  in       | input     | in_valid_i / in_stall_o | in_word_t
//  out      | output    | out_valid_o/out_stall_i | out_word_t
//  cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  Update: 16 multiply steps, 16 divide steps and 3 x 16 gain steps on one
//  shift-add accumulator; a quotient clamp skips the divide steps, a zero
//  interval skips multiply and divide, and a restart goes straight to finish.
//  One word in flight; the next word is taken once the result sits in the
//  output register. A stalled output holds the finished word until taken.
//  Async active-low reset restores gains and clears history.
// ----------------------------------------------------------------------------
`include "wheel_velocity_pid_top_macros.svh"

module wheel_velocity_pid_top #(
  parameter int COUNT_BITS = 24,
  parameter int SUM_BITS   = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  wvpid_pkg::in_word_t                  in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output wvpid_pkg::out_word_t                 out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [wvpid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wvpid_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import wvpid_pkg::*;

  localparam int PROD_W = COUNT_BITS + 16;
  localparam int DIV_W  = (COUNT_BITS + 30 > 50) ? COUNT_BITS + 30 : 50;
  localparam int ACC_W  = SUM_BITS + 19;
  localparam int PWR_W  = ACC_W - FRAC_BITS;
  localparam int SUM_W1 = SUM_BITS + 1;
  localparam logic [3:0] LAST_STEP = 4'hF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SCALE, ST_OVF, ST_DIV, ST_SPD, ST_ERR, ST_PID, ST_RND, ST_FIN
  } state_e;

  typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} term_e;

  state_e                    state_q;
  term_e                     term_q;
  logic [3:0]                cnt_q;
  logic                      neg_q, zero_q, sat_q;
  logic signed [15:0]        target_q;
  logic [33:0]               den_q;
  logic [PROD_W-1:0]         mcand_q, prod_q;
  logic [15:0]               mplier_q, quo_q, gain_q;
  logic [DIV_W-1:0]          rem_q, dsh_q;
  logic signed [15:0]        speed_q, err_q, power_q;
  logic signed [ACC_W-1:0]   op_q, acc_q;
  logic [15:0]               kp_q, ki_q, kd_q, dpc_q;
  logic [COUNT_BITS-1:0]     last_count_q;
  logic [31:0]               last_time_q;
  logic signed [15:0]        last_error_q, last_power_q;
  logic signed [SUM_BITS-1:0] error_sum_q;
  logic                      out_valid_q;
  out_word_t                 out_word_q;

  logic [COUNT_BITS+23:0]    cnt_ext_w;
  logic [COUNT_BITS-1:0]     cnt_w, dcnt_w, mag_w;
  logic [31:0]               dt_w;
  logic [15:0]               spd_w;
  logic signed [16:0]        diff_w, de_w;
  logic signed [15:0]        err_w, pow_sat_w;
  logic signed [SUM_BITS:0]  sum_w;
  logic                      sum_ovf_w, pwr_ovf_w, in_acc_w;
  logic signed [SUM_BITS-1:0] sum_sat_w;
  logic signed [PWR_W-1:0]   pwr_w;

  assign in_acc_w  = in_valid_i && !in_stall_o;
  assign cnt_ext_w = {{COUNT_BITS{1'b0}}, in_word_i.encoder_count};
  assign cnt_w     = cnt_ext_w[COUNT_BITS-1:0];
  assign dcnt_w    = cnt_w - last_count_q;
  assign mag_w     = dcnt_w[COUNT_BITS-1] ? (~dcnt_w + 1'b1) : dcnt_w;
  assign dt_w      = in_word_i.timestamp_us - last_time_q;

  always_comb begin
    if (neg_q) begin
      spd_w = (quo_q > S16_MIN) ? S16_MIN : (~quo_q + 16'd1);
    end else begin
      spd_w = quo_q[15] ? S16_MAX : quo_q;
    end
  end

  assign diff_w    = 17'(target_q) - 17'(speed_q);
  assign err_w     = (diff_w[16] != diff_w[15]) ? $signed(diff_w[16] ? S16_MIN : S16_MAX)
                                                : diff_w[15:0];
  assign sum_w     = SUM_W1'(error_sum_q) + SUM_W1'(err_w);
  assign sum_ovf_w = sum_w[SUM_BITS] != sum_w[SUM_BITS-1];
  assign sum_sat_w = sum_ovf_w ? {sum_w[SUM_BITS], {(SUM_BITS-1){~sum_w[SUM_BITS]}}}
                               : sum_w[SUM_BITS-1:0];
  // previous error is kept until rounding, so this holds through the gain steps
  assign de_w      = 17'(err_w) - 17'(last_error_q);

  assign pwr_w     = acc_q[ACC_W-1:FRAC_BITS];
  assign pwr_ovf_w = !((&pwr_w[PWR_W-1:15]) || !(|pwr_w[PWR_W-1:15]));
  assign pow_sat_w = pwr_ovf_w ? $signed(pwr_w[PWR_W-1] ? S16_MIN : S16_MAX) : pwr_w[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      term_q       <= TERM_P;
      cnt_q        <= '0;
      neg_q        <= 1'b0;
      zero_q       <= 1'b0;
      sat_q        <= 1'b0;
      target_q     <= '0;
      den_q        <= '0;
      mcand_q      <= '0;
      prod_q       <= '0;
      mplier_q     <= '0;
      quo_q        <= '0;
      gain_q       <= '0;
      rem_q        <= '0;
      dsh_q        <= '0;
      speed_q      <= '0;
      err_q        <= '0;
      power_q      <= '0;
      op_q         <= '0;
      acc_q        <= '0;
      kp_q         <= PROP_GAIN_RST;
      ki_q         <= INTEG_GAIN_RST;
      kd_q         <= DERIV_GAIN_RST;
      dpc_q        <= DIST_PER_COUNT_RST;
      last_count_q <= '0;
      last_time_q  <= '0;
      last_error_q <= '0;
      last_power_q <= '0;
      error_sum_q  <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PROP_GAIN:      kp_q  <= cfg_data_i;
          CFG_INTEG_GAIN:     ki_q  <= cfg_data_i;
          CFG_DERIV_GAIN:     kd_q  <= cfg_data_i;
          CFG_DIST_PER_COUNT: dpc_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc_w) begin
            last_count_q <= cnt_w;
            last_time_q  <= in_word_i.timestamp_us;
            sat_q        <= 1'b0;
            if (!in_word_i.cmd) begin
              last_error_q <= '0;
              last_power_q <= '0;
              error_sum_q  <= '0;
              speed_q      <= '0;
              err_q        <= '0;
              power_q      <= '0;
              zero_q       <= 1'b0;
              state_q      <= ST_FIN;
            end else begin
              neg_q    <= dcnt_w[COUNT_BITS-1];
              target_q <= in_word_i.target_speed;
              den_q    <= {dt_w, {DEN_SHIFT{1'b0}}};
              zero_q   <= (dt_w == '0);
              mcand_q  <= PROD_W'(mag_w);
              mplier_q <= dpc_q;
              prod_q   <= '0;
              cnt_q    <= '0;
              if (dt_w == '0) begin
                speed_q <= '0;
                state_q <= ST_ERR;
              end else begin
                state_q <= ST_MUL;
              end
            end
          end
        end

        ST_MUL: begin
          if (mplier_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q + 4'd1;
          if (cnt_q == LAST_STEP) begin
            state_q <= ST_SCALE;
          end
        end

        ST_SCALE: begin
          rem_q   <= DIV_W'(prod_q) * DIV_W'(SPEED_SCALE);
          dsh_q   <= DIV_W'(den_q) << 16;
          state_q <= ST_OVF;
        end

        ST_OVF: begin
          if (rem_q >= dsh_q) begin
            quo_q   <= 16'hFFFF;
            state_q <= ST_SPD;
          end else begin
            dsh_q   <= dsh_q >> 1;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (rem_q >= dsh_q) begin
            rem_q <= rem_q - dsh_q;
          end
          quo_q <= {quo_q[14:0], rem_q >= dsh_q};
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == LAST_STEP) begin
            state_q <= ST_SPD;
          end
        end

        ST_SPD: begin
          speed_q <= $signed(spd_w);
          state_q <= ST_ERR;
        end

        ST_ERR: begin
          err_q        <= err_w;
          error_sum_q  <= sum_sat_w;
          sat_q        <= sum_ovf_w;
          acc_q        <= (ACC_W'(last_power_q) <<< FRAC_BITS) + ACC_W'(ROUND_HALF);
          op_q         <= ACC_W'(err_w);
          gain_q       <= kp_q;
          term_q       <= TERM_P;
          cnt_q        <= '0;
          state_q      <= ST_PID;
        end

        ST_PID: begin
          if (gain_q[0]) begin
            acc_q <= acc_q + op_q;
          end
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == LAST_STEP) begin
            unique case (term_q)
              TERM_P: begin
                op_q   <= ACC_W'(error_sum_q);
                gain_q <= ki_q;
                term_q <= TERM_I;
              end
              TERM_I: begin
                op_q   <= ACC_W'(de_w);
                gain_q <= kd_q;
                term_q <= TERM_D;
              end
              default: begin
                state_q <= ST_RND;
              end
            endcase
          end else begin
            op_q   <= op_q <<< 1;
            gain_q <= gain_q >> 1;
          end
        end

        ST_RND: begin
          power_q      <= pow_sat_w;
          last_power_q <= pow_sat_w;
          last_error_q <= err_q;
          sat_q        <= sat_q | pwr_ovf_w;
          state_q      <= ST_FIN;
        end

        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q                <= 1'b1;
            out_word_q.drive_power     <= power_q;
            out_word_q.measured_speed  <= speed_q;
            out_word_q.speed_error     <= err_q;
            out_word_q.saturated       <= sat_q;
            out_word_q.zero_interval   <= zero_q;
            state_q                    <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `WVP_ASSERT_NOW(a_zero_speed, out_valid_o && out_word_o.zero_interval,
    out_word_o.measured_speed == 16'sd0, "zero interval with nonzero speed")
  `WVP_ASSERT_NEXT(a_busy_after_accept, in_acc_w, in_stall_o,
    "block not busy after taking a word")
  `WVP_ASSERT_NOW(a_result_from_fin, $rose(out_valid_o), $past(state_q == ST_FIN),
    "result raised outside finish state")

endmodule

/* tb/tb_wheel_velocity_pid_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wheel velocity PID - testbench
// Drives restart and update words through the valid/stall input channel,
// predicts every result word from an in-bench velocity PID model, and checks
// each field of the output words in order. Covers the register extremes,
// counter and timer wrap, zero intervals, speed and error clamping, and
// integrator windup into its clamp. Random idle and stall bursts are
// used on both sides, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_wheel_velocity_pid_top;
  import wvpid_pkg::*;

  localparam int COUNT_BITS = 24;
  localparam int SUM_BITS = 24;
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;
  localparam longint SUM_MAX = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam int DRAIN_CYCLES = 120;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  wheel_velocity_pid_top #(
    .COUNT_BITS(COUNT_BITS),
    .SUM_BITS(SUM_BITS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // controller model state
  longint kp_gain = PROP_GAIN_RST;
  longint ki_gain = INTEG_GAIN_RST;
  longint kd_gain = DERIV_GAIN_RST;
  longint inch_per_count = DIST_PER_COUNT_RST;
  logic [COUNT_BITS-1:0] base_count = '0;
  logic [31:0] base_time = '0;
  longint prev_error = 0;
  longint err_accum = 0;
  longint prev_drive = 0;

  in_word_t pending_words[$];
  out_word_t expected_results[$];
  int words_queued = 0;
  int words_accepted = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  bit quiet_tail = 1'b0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  logic [23:0] run_count = '0;
  logic [31:0] run_time = '0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp_s16(longint v, inout bit hit);
    if (v > 32767) begin
      hit = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      hit = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic out_word_t predict_wheel_result(in_word_t w);
    out_word_t r;
    logic [COUNT_BITS-1:0] dcount;
    logic [31:0] dt;
    longint sdelta, spd, err, de, acc, drv;
    longint unsigned mag, quot;
    bit sat_hit, err_hit;
    r = '0;
    sat_hit = 1'b0;
    err_hit = 1'b0;
    if (w.cmd == CMD_RESTART) begin
      base_count = w.encoder_count[COUNT_BITS-1:0];
      base_time = w.timestamp_us;
      prev_error = 0;
      err_accum = 0;
      prev_drive = 0;
      return r;
    end
    dcount = w.encoder_count[COUNT_BITS-1:0] - base_count;
    dt = w.timestamp_us - base_time;
    sdelta = longint'($signed(dcount));
    spd = 0;
    if (dt == 0) begin
      r.zero_interval = 1'b1;
    end else begin
      mag = (sdelta < 0) ? -sdelta : sdelta;
      quot = mag * inch_per_count * SPEED_SCALE / (longint'(dt) << DEN_SHIFT);
      if (sdelta < 0) spd = (quot > 32768) ? -32768 : -longint'(quot);
      else spd = (quot > 32767) ? 32767 : longint'(quot);
    end
    err = clamp_s16(longint'(w.target_speed) - spd, err_hit);
    err_accum = err_accum + err;
    if (err_accum > SUM_MAX) begin
      err_accum = SUM_MAX;
      sat_hit = 1'b1;
    end
    if (err_accum < -SUM_MAX - 1) begin
      err_accum = -SUM_MAX - 1;
      sat_hit = 1'b1;
    end
    de = err - prev_error;
    acc = prev_drive * 4096 + kp_gain * err + ki_gain * err_accum + kd_gain * de;
    drv = clamp_s16((acc + ROUND_HALF) >>> FRAC_BITS, sat_hit);
    base_count = w.encoder_count[COUNT_BITS-1:0];
    base_time = w.timestamp_us;
    prev_error = err;
    prev_drive = drv;
    r.drive_power = drv[15:0];
    r.measured_speed = spd[15:0];
    r.speed_error = err[15:0];
    r.saturated = sat_hit;
    return r;
  endfunction

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result word: %h", got);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.drive_power !== want.drive_power) begin
        $error("drive_power: expected %0d, got %0d", want.drive_power, got.drive_power);
        fail_count++;
      end
      if (got.measured_speed !== want.measured_speed) begin
        $error("measured_speed: expected %0d, got %0d", want.measured_speed,
               got.measured_speed);
        fail_count++;
      end
      if (got.speed_error !== want.speed_error) begin
        $error("speed_error: expected %0d, got %0d", want.speed_error, got.speed_error);
        fail_count++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        fail_count++;
      end
      if (got.zero_interval !== want.zero_interval) begin
        $error("zero_interval: expected %0b, got %0b", want.zero_interval, got.zero_interval);
        fail_count++;
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap == 0 && pending_words.size() != 0 && !quiet_tail) begin
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        if (!send_calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word_i <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet_tail) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        if (!recv_calm && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 15) - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_wheel_result(in_word_i));
        words_accepted++;
      end
      if (out_valid_o && !out_stall_i) check_result(out_word_o);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PROP_GAIN: kp_gain = val;
      CFG_INTEG_GAIN: ki_gain = val;
      CFG_DERIV_GAIN: kd_gain = val;
      CFG_DIST_PER_COUNT: inch_per_count = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                          logic [15:0] dpc);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_DIST_PER_COUNT, dpc);
  endtask

  task automatic wait_idle();
    while (words_accepted != words_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_word(logic c, logic [23:0] cnt, logic [31:0] ts, logic [15:0] tgt);
    in_word_t w;
    w.cmd = c;
    w.encoder_count = cnt;
    w.timestamp_us = ts;
    w.target_speed = tgt;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_restart();
    run_count = 24'($urandom);
    run_time = $urandom;
    queue_word(CMD_RESTART, run_count, run_time, 16'($urandom));
  endtask

  task automatic queue_update(logic [23:0] dc, logic [31:0] dt, logic [15:0] tgt);
    run_count = run_count + dc;
    run_time = run_time + dt;
    queue_word(CMD_UPDATE, run_count, run_time, tgt);
  endtask

  task automatic queue_traffic(int n);
    int k;
    int run;
    logic [23:0] dc;
    logic [31:0] dt;
    logic [15:0] tgt;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_word($urandom_range(0, 3) != 0, 24'($urandom), $urandom, 16'($urandom));
        k++;
      end else begin
        queue_restart();
        k++;
        run = $urandom_range(3, 20);
        repeat (run) begin
          case ($urandom_range(0, 15))
            0: dt = 0;
            1: dt = $urandom_range(1, 50);
            2: dt = $urandom;
            default: dt = $urandom_range(1000, 200000);
          endcase
          if ($urandom_range(0, 15) == 0) dc = 24'($urandom);
          else dc = 24'($urandom_range(0, 4000) - 2000);
          if ($urandom_range(0, 3) == 0) tgt = 16'($urandom);
          else tgt = 16'($urandom_range(0, 12000) - 6000);
          queue_update(dc, dt, tgt);
          k++;
        end
      end
    end
  endtask

  // long runs of near full-scale error to drive the integrator into its clamp
  task automatic queue_windup(bit negative, int n);
    logic [31:0] dt;
    logic [15:0] tgt;
    queue_restart();
    repeat (n) begin
      dt = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1000, 200000));
      if (negative) tgt = 16'h8000 + 16'($urandom_range(0, 255));
      else tgt = 16'h7FFF - 16'($urandom_range(0, 255));
      queue_update(24'($urandom_range(0, 3)), dt, tgt);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, reset register values
    queue_word(CMD_UPDATE, 24'd150, 32'd150000, 16'h0A00);
    queue_word(CMD_UPDATE, 24'd200, 32'd150000, 16'h0000);
    queue_word(CMD_RESTART, 24'hFFFFF0, 32'hFFFFFFF0, 16'h7FFF);
    queue_word(CMD_UPDATE, 24'h000020, 32'h00000100, 16'h8000);
    queue_word(CMD_UPDATE, 24'h800020, 32'h00000101, 16'h7FFF);
    queue_word(CMD_UPDATE, 24'h00001F, 32'h00000100, 16'h0000);
    queue_word(CMD_UPDATE, 24'h00001F, 32'h00024AF0, 16'h0000);
    queue_word(CMD_RESTART, 24'h000000, 32'h00000000, 16'h8000);
    queue_word(CMD_UPDATE, 24'd50, 32'd150000, 16'h0C00);
    queue_word(CMD_UPDATE, 24'd98, 32'd300000, 16'h0C00);
    queue_word(CMD_UPDATE, 24'd140, 32'd450000, 16'h0C00);
    queue_word(CMD_UPDATE, 24'd120, 32'd600000, 16'hF400);
    queue_word(CMD_RESTART, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    queue_word(CMD_UPDATE, 24'hFFFFFF, 32'hFFFFFFFF, 16'h8000);
    queue_word(CMD_UPDATE, 24'h000000, 32'h00000000, 16'h0000);
    queue_word(CMD_UPDATE, 24'h555555, 32'hAAAAAAAA, 16'h5555);
    queue_word(CMD_UPDATE, 24'hAAAAAA, 32'h55555555, 16'hAAAA);
    wait_idle();

    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_traffic(50);
    wait_idle();

    set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_traffic(40);
    wait_idle();

    set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    queue_windup(1'b0, 262);
    hold_req = 1'b1;
    queue_traffic(20);
    wait_idle();

    set_regs(16'($urandom), 16'($urandom_range(0, 1000)), 16'($urandom), 16'($urandom));
    quiet_tail = 1'b1;
    queue_traffic(50);
    wait_idle();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/wvpid_pkg.sv
hdl/wheel_velocity_pid_top.sv
tb/tb_wheel_velocity_pid_top.sv
